/* design/adm_pkg.sv */
// Shared types, constants and codes for the audio delay multi-effect core.
package adm_pkg;

  localparam int DELAY_DEPTH = 16384;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_BITS = $clog2(DELAY_DEPTH);
  localparam int SHIFT_BITS = $clog2(SAMPLE_BITS);
  localparam int DAC_BITS = 12;
  localparam int AMOUNT_BITS = 12;
  localparam int MODE_BITS = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [ADDR_BITS-1:0] ECHO_BASE = ADDR_BITS'(4900);
  localparam logic [ADDR_BITS-1:0] CHORUS_BASE = ADDR_BITS'(480);
  localparam logic [15:0] GAIN_ECHO_Q16 = 16'd13107;
  localparam logic [15:0] GAIN_CHORUS_Q16 = 16'd19661;
  localparam logic [3:0] CRUSH_SPAN = 4'd11;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS = OUT_PTR_BITS + 1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_AMOUNT = CFG_INDEX_BITS'(1);

  typedef enum logic [MODE_BITS-1:0] {
    MODE_PASS   = 2'd0,
    MODE_CRUSH  = 2'd1,
    MODE_CHORUS = 2'd2,
    MODE_ECHO   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [ADDR_BITS-1:0]   wr_addr;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic                   hist_ok;
    mode_t                  mode;
    logic [SHIFT_BITS-1:0]  shift;
  } job_t;

endpackage

/* design/adm_front.sv */
// Front end: config registers, write pointer and per-sample job classification.
module adm_front import adm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      take,
  input  logic [SAMPLE_BITS-1:0]    sample_in,
  output job_t                      job
);

  mode_t                  effect_mode;
  logic [AMOUNT_BITS-1:0] effect_amount;
  logic [ADDR_BITS-1:0]   write_pointer;
  logic                   filled;
  logic [ADDR_BITS-1:0]   delay;
  logic [15:0]            crush_prod;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode   <= MODE_PASS;
      effect_amount <= '0;
      write_pointer <= '0;
      filled        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MODE) begin
          effect_mode <= mode_t'(cfg_data[MODE_BITS-1:0]);
        end else if (cfg_index == CFG_AMOUNT) begin
          effect_amount <= cfg_data[AMOUNT_BITS-1:0];
        end
      end
      if (take) begin
        write_pointer <= write_pointer + 1'b1;
        if (write_pointer == ADDR_BITS'(DELAY_DEPTH - 1)) begin
          filled <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (effect_mode == MODE_ECHO) begin
      delay = ADDR_BITS'(effect_amount) + ECHO_BASE;
    end else begin
      delay = ADDR_BITS'(effect_amount >> 1) + CHORUS_BASE;
    end
    crush_prod = 16'(effect_amount) * 16'(CRUSH_SPAN);
    job.sample  = sample_in;
    job.wr_addr = write_pointer;
    job.rd_addr = write_pointer - delay;
    // an entry older than everything written so far still reads as zero
    job.hist_ok = filled || (write_pointer >= delay);
    job.mode    = effect_mode;
    job.shift   = SHIFT_BITS'(SAMPLE_BITS - 1) - SHIFT_BITS'(crush_prod[15:12]);
  end

endmodule

/* design/adm_queue.sv */
// Short job queue between the front end and the effect pipeline.
module adm_queue import adm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t                      slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;
  logic                      do_push;
  logic                      do_pop;

  assign full    = (count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/adm_back.sv */
// Effect pipeline: delay store read, gain multiply, mix, write-back, result buffer.
module adm_back import adm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  job_t                q_job,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output logic [DAC_BITS-1:0] dac_value
);

  logic [SAMPLE_BITS-1:0] delay_store [DELAY_DEPTH];

  logic                   s1_valid;
  job_t                   s1_job;
  logic [SAMPLE_BITS-1:0] s1_rd_data;
  logic [SAMPLE_BITS-1:0] s1_delayed;
  logic [15:0]            s1_gain;
  logic [31:0]            s1_prod;

  logic                   s2_valid;
  job_t                   s2_job;
  logic [15:0]            s2_scaled;
  logic [16:0]            s2_sum;
  logic [SAMPLE_BITS-1:0] s2_mix;
  logic [SAMPLE_BITS-1:0] s2_crushed;
  logic [SAMPLE_BITS-1:0] s2_result;
  logic [SAMPLE_BITS-1:0] s2_store;

  logic [DAC_BITS-1:0]     out_buf [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0] out_wr_ptr;
  logic [OUT_PTR_BITS-1:0] out_rd_ptr;
  logic [OUT_CNT_BITS-1:0] out_count;
  logic [OUT_CNT_BITS:0]   committed;
  logic                    out_pop;
  logic                    rd_en;

  // issue only when the result buffer has room for every beat in flight
  assign committed = (OUT_CNT_BITS+1)'(out_count) + (OUT_CNT_BITS+1)'(s1_valid)
                   + (OUT_CNT_BITS+1)'(s2_valid);
  assign q_pop   = !q_empty && (committed < (OUT_CNT_BITS+1)'(OUT_DEPTH));
  assign rd_en   = q_pop && (q_job.mode == MODE_CHORUS || q_job.mode == MODE_ECHO);
  assign empty   = (out_count == '0);
  assign out_pop = pop && !empty;
  assign dac_value = out_buf[out_rd_ptr];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_rd_data <= delay_store[q_job.rd_addr];
    end
    if (s2_valid) begin
      delay_store[s2_job.wr_addr] <= s2_store;
    end
  end

  always_comb begin
    s1_delayed = s1_job.hist_ok ? s1_rd_data : '0;
    s1_gain    = (s1_job.mode == MODE_ECHO) ? GAIN_ECHO_Q16 : GAIN_CHORUS_Q16;
    s1_prod    = 32'(s1_delayed) * 32'(s1_gain);
  end

  always_comb begin
    s2_sum     = 17'(s2_job.sample) + 17'(s2_scaled);
    s2_mix     = s2_sum[16] ? 16'hFFFF : s2_sum[15:0];
    s2_crushed = s2_job.sample & (16'hFFFF << s2_job.shift);
    case (s2_job.mode)
      MODE_CRUSH:  s2_result = s2_crushed;
      MODE_CHORUS: s2_result = s2_mix;
      MODE_ECHO:   s2_result = s2_mix;
      default:     s2_result = s2_job.sample;
    endcase
    s2_store = (s2_job.mode == MODE_ECHO) ? s2_mix : s2_job.sample;
  end

  always_ff @(posedge clk) begin
    s1_job    <= q_job;
    s2_job    <= s1_job;
    s2_scaled <= s1_prod[31:16];
    if (s2_valid) begin
      out_buf[out_wr_ptr] <= s2_result[SAMPLE_BITS-1:SAMPLE_BITS-DAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      out_wr_ptr <= '0;
      out_rd_ptr <= '0;
      out_count  <= '0;
    end else begin
      s1_valid <= q_pop;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        out_wr_ptr <= out_wr_ptr + 1'b1;
      end
      if (out_pop) begin
        out_rd_ptr <= out_rd_ptr + 1'b1;
      end
      if (s2_valid && !out_pop) begin
        out_count <= out_count + 1'b1;
      end else if (out_pop && !s2_valid) begin
        out_count <= out_count - 1'b1;
      end
    end
  end

  a_credit: assert property (@(posedge clk) disable iff (rst)
    committed <= (OUT_CNT_BITS+1)'(OUT_DEPTH))
    else $error("result buffer overcommitted");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (out_count < OUT_CNT_BITS'(OUT_DEPTH)) || out_pop)
    else $error("result buffer overflow");

  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    (rd_en && s2_valid) |-> (q_job.rd_addr != s2_job.wr_addr))
    else $error("delay read collides with write-back");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    s2_valid |=> !empty)
    else $error("result beat lost");

endmodule

/* design/audio_delay_multi_effect_core.sv */
// Top level of the audio delay multi-effect core.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------
//  sample   | push / full          | sample_in[15:0]
//  result   | pop / empty          | dac_value[11:0]
//  config   | cfg_valid/cfg_ready  | cfg_index[1:0], cfg_data[11:0]
//
// One sample per cycle sustained while the result side keeps popping; a result
// passes through the job queue, the registered delay store read, the
// registered gain multiply and the result buffer. The delay store is a single
// RAM, one read and one write per cycle. Reset needs no clearing pass: history
// not yet written reads as zero. A stalled result side fills the result buffer,
// then the job queue, then raises full. cfg_ready is always high.
module audio_delay_multi_effect_core import adm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [SAMPLE_BITS-1:0]    sample_in,
  output logic                      empty,
  input  logic                      pop,
  output logic [DAC_BITS-1:0]       dac_value,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  job_t front_job;
  job_t q_job;
  logic take;
  logic q_empty;
  logic q_pop;

  assign take = push && !full;

  adm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .sample_in (sample_in),
    .job       (front_job)
  );

  adm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (front_job),
    .full     (full),
    .pop      (q_pop),
    .pop_job  (q_job),
    .empty    (q_empty)
  );

  adm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .dac_value (dac_value)
  );

endmodule
